### rtl/mmsdc_pkg.sv
// Shared types and codes for the min/max stack with duplicate counts.
// No dependencies.
package mmsdc_pkg;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_SRCH,
    ST_POP_LAST,
    ST_SCAN,
    ST_DONE
  } state_e;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

endpackage

### rtl/mmsdc_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. No dependencies.
module mmsdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/min_max_stack_with_duplicate_counts_core.sv
// Top level of the min/max stack with duplicate counts.
// Depends on mmsdc_pkg and mmsdc_ram (stack store and distinct table).
//
//   channel   handshake            ports
//   request   start, busy          req_type_i, push_value_i
//   result    done_o (strobe)      cur_max_o, cur_min_o, popped_value_o,
//                                  stack_count_o, distinct_count_o, status_o
//
// Busy stays high from an accepted start through the done_o strobe, which is
// carried by the last busy cycle; a refused request goes straight to done.
// The distinct table has a single read port; it is walked once for the
// lookup and, on a pop that removes an entry, once more for the min/max
// rescan.
// Reset clears the counters and min/max; the RAMs are not cleared. The done_o
// strobe is high for one cycle only and cannot be held off.
module min_max_stack_with_duplicate_counts_core #(
  parameter int DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [31:0] push_value_i,
  output logic        done_o,
  output logic [31:0] cur_max_o,
  output logic [31:0] cur_min_o,
  output logic [31:0] popped_value_o,
  output logic [6:0]  stack_count_o,
  output logic [6:0]  distinct_count_o,
  output logic [1:0]  status_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = CW + 32;

  mmsdc_pkg::state_e  state_q, state_d;
  mmsdc_pkg::status_e status_q, status_d;

  logic [CW-1:0] top_q, top_d;
  logic [CW-1:0] total_q, total_d;
  logic [31:0]   max_q, max_d;
  logic [31:0]   min_q, min_d;
  logic [31:0]   popped_q, popped_d;
  logic [31:0]   key_q, key_d;
  logic          pop_q, pop_d;
  logic [CW-1:0] issue_q, issue_d;
  logic          vld_q, vld_d;
  logic [AW-1:0] cmp_q, cmp_d;
  logic [AW-1:0] idx_q, idx_d;

  logic          v_we, v_re;
  logic [AW-1:0] v_waddr, v_raddr;
  logic [31:0]   v_wdata, v_rdata;
  logic          d_we, d_re;
  logic [AW-1:0] d_waddr, d_raddr;
  logic [DW-1:0] d_wdata, d_rdata;

  logic [31:0]   d_rval;
  logic [CW-1:0] d_rcnt;
  logic [CW-1:0] top_m1, total_m1;
  logic          hit;

  assign d_rval   = d_rdata[31:0];
  assign d_rcnt   = d_rdata[DW-1:32];
  assign top_m1   = top_q - CW'(1);
  assign total_m1 = total_q - CW'(1);
  assign hit      = vld_q && (d_rval == key_q);

  mmsdc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  mmsdc_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_distinct_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mmsdc_pkg::ST_IDLE;
      status_q <= mmsdc_pkg::STAT_OK;
      top_q    <= '0;
      total_q  <= '0;
      max_q    <= '0;
      min_q    <= '0;
      popped_q <= '0;
      pop_q    <= 1'b0;
      issue_q  <= '0;
      vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      top_q    <= top_d;
      total_q  <= total_d;
      max_q    <= max_d;
      min_q    <= min_d;
      popped_q <= popped_d;
      pop_q    <= pop_d;
      issue_q  <= issue_d;
      vld_q    <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cmp_q <= cmp_d;
    idx_q <= idx_d;
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    top_d    = top_q;
    total_d  = total_q;
    max_d    = max_q;
    min_d    = min_q;
    popped_d = popped_q;
    key_d    = key_q;
    pop_d    = pop_q;
    issue_d  = issue_q;
    vld_d    = vld_q;
    cmp_d    = cmp_q;
    idx_d    = idx_q;
    v_we     = 1'b0;
    v_waddr  = top_q[AW-1:0];
    v_wdata  = push_value_i;
    v_re     = 1'b0;
    v_raddr  = top_m1[AW-1:0];
    d_we     = 1'b0;
    d_waddr  = cmp_q;
    d_wdata  = d_rdata;
    d_re     = 1'b0;
    d_raddr  = issue_q[AW-1:0];

    unique case (state_q)
      mmsdc_pkg::ST_IDLE: begin
        if (start) begin
          status_d = mmsdc_pkg::STAT_OK;
          popped_d = '0;
          issue_d  = '0;
          vld_d    = 1'b0;
          key_d    = push_value_i;
          pop_d    = (req_type_i == mmsdc_pkg::REQ_POP);
          if (req_type_i == mmsdc_pkg::REQ_PUSH) begin
            if (top_q == CW'(DEPTH)) begin
              status_d = mmsdc_pkg::STAT_FULL;
              state_d  = mmsdc_pkg::ST_DONE;
            end else begin
              v_we  = 1'b1;
              top_d = top_q + CW'(1);
              if (top_q == '0) begin
                max_d = push_value_i;
                min_d = push_value_i;
              end else begin
                if (push_value_i > max_q) max_d = push_value_i;
                if (push_value_i < min_q) min_d = push_value_i;
              end
              state_d = mmsdc_pkg::ST_SRCH;
            end
          end else begin
            if (top_q == '0) begin
              status_d = mmsdc_pkg::STAT_EMPTY;
              state_d  = mmsdc_pkg::ST_DONE;
            end else begin
              v_re    = 1'b1;
              top_d   = top_m1;
              state_d = mmsdc_pkg::ST_POP_RD;
            end
          end
        end
      end

      mmsdc_pkg::ST_POP_RD: begin
        key_d    = v_rdata;
        popped_d = v_rdata;
        state_d  = mmsdc_pkg::ST_SRCH;
      end

      mmsdc_pkg::ST_SRCH: begin
        // issue one read a cycle, compare the word that came back
        if (issue_q < total_q) begin
          d_re    = 1'b1;
          issue_d = issue_q + CW'(1);
          cmp_d   = issue_q[AW-1:0];
          vld_d   = 1'b1;
        end else begin
          vld_d = 1'b0;
        end
        if (hit) begin
          if (!pop_q) begin
            d_we    = 1'b1;
            d_wdata = {d_rcnt + CW'(1), d_rval};
            state_d = mmsdc_pkg::ST_DONE;
          end else if (d_rcnt > CW'(1)) begin
            d_we    = 1'b1;
            d_wdata = {d_rcnt - CW'(1), d_rval};
            state_d = mmsdc_pkg::ST_DONE;
          end else begin
            // last occurrence: fetch the tail entry to fill the hole
            idx_d   = cmp_q;
            d_re    = 1'b1;
            d_raddr = total_m1[AW-1:0];
            total_d = total_m1;
            state_d = mmsdc_pkg::ST_POP_LAST;
          end
        end else if (issue_q == total_q && !vld_q) begin
          if (!pop_q) begin
            d_we    = 1'b1;
            d_waddr = total_q[AW-1:0];
            d_wdata = {CW'(1), key_q};
            total_d = total_q + CW'(1);
          end
          state_d = mmsdc_pkg::ST_DONE;
        end
      end

      mmsdc_pkg::ST_POP_LAST: begin
        d_we    = 1'b1;
        d_waddr = idx_q;
        d_wdata = d_rdata;
        issue_d = '0;
        vld_d   = 1'b0;
        max_d   = '0;
        min_d   = '0;
        state_d = mmsdc_pkg::ST_SCAN;
      end

      mmsdc_pkg::ST_SCAN: begin
        if (issue_q < total_q) begin
          d_re    = 1'b1;
          issue_d = issue_q + CW'(1);
          cmp_d   = issue_q[AW-1:0];
          vld_d   = 1'b1;
        end else begin
          vld_d = 1'b0;
        end
        if (vld_q) begin
          if (cmp_q == '0) begin
            max_d = d_rval;
            min_d = d_rval;
          end else begin
            if (d_rval > max_q) max_d = d_rval;
            if (d_rval < min_q) min_d = d_rval;
          end
        end
        if (issue_q == total_q && !vld_q) begin
          state_d = mmsdc_pkg::ST_DONE;
        end
      end

      mmsdc_pkg::ST_DONE: begin
        state_d = mmsdc_pkg::ST_IDLE;
      end

      default: begin
        state_d = mmsdc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy             = (state_q != mmsdc_pkg::ST_IDLE);
  assign done_o           = (state_q == mmsdc_pkg::ST_DONE);
  assign cur_max_o        = max_q;
  assign cur_min_o        = min_q;
  assign popped_value_o   = popped_q;
  assign stack_count_o    = 7'(top_q);
  assign distinct_count_o = 7'(total_q);
  assign status_o         = status_q;

endmodule

### test/tb_top.sv
// Testbench for min_max_stack_with_duplicate_counts_core: directed and random push/pop
// words checked field by field against a behavioural stack kept in this module.
// Depends on mmsdc_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth    = 64;
  localparam int NumItems = 1700;
  localparam int MaxShown = 10;

  typedef struct {
    logic        op;
    logic [31:0] value;
  } stack_op_t;

  typedef struct {
    logic [31:0]        max_val;
    logic [31:0]        min_val;
    logic [31:0]        popped;
    logic [6:0]         stack_cnt;
    logic [6:0]         distinct_cnt;
    mmsdc_pkg::status_e status;
  } outcome_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        req_type_i   = mmsdc_pkg::REQ_PUSH;
  logic [31:0] push_value_i = '0;
  logic        busy;
  logic        done_o;
  logic [31:0] cur_max_o;
  logic [31:0] cur_min_o;
  logic [31:0] popped_value_o;
  logic [6:0]  stack_count_o;
  logic [6:0]  distinct_count_o;
  logic [1:0]  status_o;

  min_max_stack_with_duplicate_counts_core #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .push_value_i    (push_value_i),
    .done_o          (done_o),
    .cur_max_o       (cur_max_o),
    .cur_min_o       (cur_min_o),
    .popped_value_o  (popped_value_o),
    .stack_count_o   (stack_count_o),
    .distinct_count_o(distinct_count_o),
    .status_o        (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stack_op_t op_q[$];
  outcome_t  outcome_q[$];

  // Shadow copy of the stack, the distinct table and the bounds
  logic [31:0] shadow_stack[Depth];
  logic [31:0] uniq_vals[Depth];
  int unsigned uniq_cnts[Depth];
  int unsigned stack_top  = 0;
  int unsigned uniq_total = 0;
  logic [31:0] max_q      = '0;
  logic [31:0] min_q      = '0;

  int unsigned faults    = 0;
  int unsigned idle_left = 0;
  int unsigned calm_left = 0;
  bit          fresh     = 1'b1;

  function automatic void note_fault(string msg);
    if (faults < MaxShown) $display("%0t: %s", $realtime, msg);
    faults++;
  endfunction

  function automatic int find_uniq(logic [31:0] v);
    for (int i = 0; i < int'(uniq_total); i++) begin
      if (uniq_vals[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t apply_stack_op(stack_op_t w);
    outcome_t    res;
    int          idx;
    int unsigned tail;
    logic [31:0] lo;
    logic [31:0] hi;
    res.status = mmsdc_pkg::STAT_OK;
    res.popped = '0;
    if (w.op == mmsdc_pkg::REQ_PUSH) begin
      if (stack_top >= Depth) begin
        res.status = mmsdc_pkg::STAT_FULL;
      end else begin
        if (stack_top == 0) begin
          max_q = w.value;
          min_q = w.value;
        end
        if (w.value > max_q) max_q = w.value;
        if (w.value < min_q) min_q = w.value;
        idx = find_uniq(w.value);
        if (idx >= 0) begin
          uniq_cnts[idx]++;
        end else begin
          uniq_vals[uniq_total] = w.value;
          uniq_cnts[uniq_total] = 1;
          uniq_total++;
        end
        shadow_stack[stack_top] = w.value;
        stack_top++;
      end
    end else if (stack_top == 0) begin
      res.status = mmsdc_pkg::STAT_EMPTY;
    end else begin
      stack_top--;
      res.popped = shadow_stack[stack_top];
      idx = find_uniq(res.popped);
      if (idx >= 0) begin
        if (uniq_cnts[idx] <= 1) begin
          // drop the entry by moving the last one into its slot, then rescan
          tail = uniq_total - 1;
          uniq_vals[idx] = uniq_vals[tail];
          uniq_cnts[idx] = uniq_cnts[tail];
          uniq_total = tail;
          if (uniq_total == 0) begin
            lo = '0;
            hi = '0;
          end else begin
            lo = uniq_vals[0];
            hi = uniq_vals[0];
            for (int i = 1; i < int'(uniq_total); i++) begin
              if (uniq_vals[i] < lo) lo = uniq_vals[i];
              if (uniq_vals[i] > hi) hi = uniq_vals[i];
            end
          end
          min_q = lo;
          max_q = hi;
        end else begin
          uniq_cnts[idx]--;
        end
      end
    end
    res.max_val      = max_q;
    res.min_val      = min_q;
    res.stack_cnt    = 7'(stack_top);
    res.distinct_cnt = 7'(uniq_total);
    return res;
  endfunction

  // Driver: offer the head word, then hold off for a random gap after each accept
  always @(negedge clk_i) begin : driver
    int unsigned roll;
    if (rst_ni) begin
      if (fresh) begin
        fresh = 1'b0;
        if (calm_left > 0) begin
          calm_left--;
          idle_left = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 2) calm_left = $urandom_range(20, 80);
          if (roll < 45) idle_left = 0;
          else if (roll < 90) idle_left = $urandom_range(1, 3);
          else if (roll < 97) idle_left = $urandom_range(4, 12);
          else idle_left = $urandom_range(20, 60);
        end
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (op_q.size() > 0) begin
        start        <= 1'b1;
        req_type_i   <= op_q[0].op;
        push_value_i <= op_q[0].value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each result strobe, predict on each accepted word
  always @(posedge clk_i) begin : monitor
    outcome_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          note_fault("result word with nothing expected");
        end else begin
          want = outcome_q.pop_front();
          if (cur_max_o !== want.max_val)
            note_fault($sformatf("cur_max: expected %h, got %h", want.max_val, cur_max_o));
          if (cur_min_o !== want.min_val)
            note_fault($sformatf("cur_min: expected %h, got %h", want.min_val, cur_min_o));
          if (popped_value_o !== want.popped)
            note_fault($sformatf("popped_value: expected %h, got %h",
                                 want.popped, popped_value_o));
          if (stack_count_o !== want.stack_cnt)
            note_fault($sformatf("stack_count: expected %0d, got %0d",
                                 want.stack_cnt, stack_count_o));
          if (distinct_count_o !== want.distinct_cnt)
            note_fault($sformatf("distinct_count: expected %0d, got %0d",
                                 want.distinct_cnt, distinct_count_o));
          if (status_o !== want.status)
            note_fault($sformatf("status: expected %0d, got %0d", want.status, status_o));
        end
      end
      if (start && !busy) begin
        outcome_q.push_back(apply_stack_op(op_q.pop_front()));
        fresh = 1'b1;
      end
    end
  end

  initial begin : stimulus
    stack_op_t   w;
    int unsigned push_pct;
    int unsigned value_mode;
    int unsigned phase_len;
    int unsigned kind;

    // Directed: pop on empty, extremes, duplicates, entry removal, drain to empty
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'hFFFF_FFFF});
    op_q.push_back('{mmsdc_pkg::REQ_PUSH, 32'h0000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_PUSH, 32'hFFFF_FFFF});
    op_q.push_back('{mmsdc_pkg::REQ_PUSH, 32'h0000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_PUSH, 32'h0000_0005});
    op_q.push_back('{mmsdc_pkg::REQ_PUSH, 32'hFFFF_FFFF});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'h0000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'hAAAA_AAAA});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'h5555_5555});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'h0000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'h0000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'h0000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_PUSH, 32'h8000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_PUSH, 32'h7FFF_FFFF});
    op_q.push_back('{mmsdc_pkg::REQ_PUSH, 32'h8000_0001});
    op_q.push_back('{mmsdc_pkg::REQ_PUSH, 32'h7FFF_FFFF});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'h0000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'h0000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'h0000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'h0000_0000});
    op_q.push_back('{mmsdc_pkg::REQ_POP,  32'h0000_0000});

    // Random phases: push-heavy bursts head toward a full stack, pop-heavy ones toward empty
    while (op_q.size() < NumItems + 21) begin
      kind       = $urandom_range(0, 3);
      value_mode = $urandom_range(0, 3);
      case (kind)
        0: begin
          push_pct  = 50;
          phase_len = $urandom_range(20, 100);
        end
        1: begin
          push_pct  = 90;
          phase_len = $urandom_range(60, 120);
        end
        2: begin
          push_pct  = 10;
          phase_len = $urandom_range(60, 120);
        end
        default: begin
          push_pct  = 65;
          phase_len = $urandom_range(20, 100);
        end
      endcase
      repeat (phase_len) begin
        w.op = ($urandom_range(0, 99) < push_pct) ? mmsdc_pkg::REQ_PUSH : mmsdc_pkg::REQ_POP;
        case (value_mode)
          0: w.value = $urandom;
          1: w.value = $urandom_range(0, 7);
          2: begin
            case ($urandom_range(0, 4))
              0: w.value = 32'h0000_0000;
              1: w.value = 32'hFFFF_FFFF;
              2: w.value = 32'h7FFF_FFFF;
              3: w.value = 32'h8000_0000;
              default: w.value = 32'h0000_0001;
            endcase
          end
          default: w.value = 32'hFFFF_FFF0 | $urandom_range(0, 15);
        endcase
        op_q.push_back(w);
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (op_q.size() == 0);
    wait (outcome_q.size() == 0);
    // catch any stray result strobes
    repeat (150) @(posedge clk_i);
    if (faults == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

### files.f
rtl/mmsdc_pkg.sv
rtl/mmsdc_ram.sv
rtl/min_max_stack_with_duplicate_counts_core.sv
test/tb_top.sv
